// ----- rtl/core/rmq_pkg.sv -----
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // Magnitudes are normalised so that the largest lies in [2^29, 2^30).
    localparam int NORM_TOP  = 30;
    localparam int SQ_WIDTH  = 2 * NORM_TOP;
    localparam int SUM_WIDTH = SQ_WIDTH + 2;
    localparam int ROOT_WIDTH = SUM_WIDTH / 2;

    localparam logic [1:0] CASE_W = 2'd0;
    localparam logic [1:0] CASE_X = 2'd1;
    localparam logic [1:0] CASE_Y = 2'd2;
    localparam logic [1:0] CASE_Z = 2'd3;

    typedef struct packed {
        logic [3:0][NORM_TOP-1:0] mag;
        logic [3:0]               neg;
        logic [1:0]               dcase;
        logic                     bad;
    } t_side;

endpackage

// ----- rtl/core/rmq_prep.sv -----
`timescale 1ns / 1ps

module rmq_prep #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [DATA_WIDTH-1:0] i_m [9],
    output logic                         o_valid,
    output rmq_pkg::t_side               o_side
);

    localparam int VW  = ((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1) + 3;
    localparam int NT  = rmq_pkg::NORM_TOP;
    localparam int LW  = $clog2(VW + 1);
    localparam logic signed [VW-1:0] ONE = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [VW-1:0] e [9];
    logic signed [VW-1:0] trace;
    logic signed [VW-1:0] n_v [4];
    logic signed [VW-1:0] n_r;
    logic [1:0]           n_dcase;

    logic                 r_v1;
    logic signed [VW-1:0] r_vec [4];
    logic                 r_bad1;
    logic [1:0]           r_dcase1;

    logic                 r_v2;
    logic [VW-1:0]        r_mag2 [4];
    logic [3:0]           r_neg2;
    logic [VW-1:0]        r_mx01;
    logic [VW-1:0]        r_mx23;
    logic                 r_bad2;
    logic [1:0]           r_dcase2;

    logic                 r_v3;
    logic [VW-1:0]        r_mag3 [4];
    logic [3:0]           r_neg3;
    logic [LW-1:0]        r_len3;
    logic                 r_bad3;
    logic [1:0]           r_dcase3;

    logic [VW-1:0]        mx;
    logic [LW-1:0]        n_len;
    logic [VW+NT-1:0]     wide [4];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            e[i] = VW'(i_m[i]);
        end
        trace = e[0] + e[4] + e[8];
        if (trace > 0) begin
            n_dcase = rmq_pkg::CASE_W;
            n_r     = trace + ONE;
            n_v[0]  = e[5] - e[7];
            n_v[1]  = e[6] - e[2];
            n_v[2]  = e[1] - e[3];
            n_v[3]  = n_r;
        end else if (e[0] > e[4] && e[0] > e[8]) begin
            n_dcase = rmq_pkg::CASE_X;
            n_r     = ONE + e[0] - e[4] - e[8];
            n_v[0]  = n_r;
            n_v[1]  = e[1] + e[3];
            n_v[2]  = e[2] + e[6];
            n_v[3]  = e[5] - e[7];
        end else if (e[4] > e[8]) begin
            n_dcase = rmq_pkg::CASE_Y;
            n_r     = ONE + e[4] - e[0] - e[8];
            n_v[0]  = e[1] + e[3];
            n_v[1]  = n_r;
            n_v[2]  = e[5] + e[7];
            n_v[3]  = e[6] - e[2];
        end else begin
            n_dcase = rmq_pkg::CASE_Z;
            n_r     = ONE + e[8] - e[0] - e[4];
            n_v[0]  = e[2] + e[6];
            n_v[1]  = e[5] + e[7];
            n_v[2]  = n_r;
            n_v[3]  = e[1] - e[3];
        end
    end

    always_comb begin
        mx    = (r_mx01 > r_mx23) ? r_mx01 : r_mx23;
        n_len = '0;
        for (int i = 0; i < VW; i++) begin
            if (mx[i]) begin
                n_len = LW'(i + 1);
            end
        end
        for (int i = 0; i < 4; i++) begin
            wide[i] = {r_mag3[i], {NT{1'b0}}} >> r_len3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec    <= n_v;
            r_bad1   <= (n_r <= 0);
            r_dcase1 <= n_dcase;

            for (int i = 0; i < 4; i++) begin
                r_neg2[i] <= r_vec[i][VW-1];
                r_mag2[i] <= r_vec[i][VW-1] ? VW'(-r_vec[i]) : VW'(r_vec[i]);
            end
            r_mx01 <= (abs_of(r_vec[0]) > abs_of(r_vec[1])) ?
                      abs_of(r_vec[0]) : abs_of(r_vec[1]);
            r_mx23 <= (abs_of(r_vec[2]) > abs_of(r_vec[3])) ?
                      abs_of(r_vec[2]) : abs_of(r_vec[3]);
            r_bad2   <= r_bad1;
            r_dcase2 <= r_dcase1;

            r_mag3   <= r_mag2;
            r_neg3   <= r_neg2;
            r_len3   <= n_len;
            r_bad3   <= r_bad2;
            r_dcase3 <= r_dcase2;

            for (int i = 0; i < 4; i++) begin
                o_side.mag[i] <= wide[i][NT-1:0];
            end
            o_side.neg   <= r_neg3;
            o_side.bad   <= r_bad3;
            o_side.dcase <= r_dcase3;
        end
    end

    function automatic logic [VW-1:0] abs_of(input logic signed [VW-1:0] x);
        logic [VW-1:0] res;
        res = x[VW-1] ? VW'(-x) : VW'(x);
        return res;
    endfunction

endmodule

// ----- rtl/core/rmq_isqrt.sv -----
`timescale 1ns / 1ps

module rmq_isqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [rmq_pkg::SUM_WIDTH-1:0]       i_sum,
    input  rmq_pkg::t_side                      i_side,
    output logic                                o_valid,
    output logic [rmq_pkg::ROOT_WIDTH-1:0]      o_root,
    output rmq_pkg::t_side                      o_side
);

    localparam int SW = rmq_pkg::SUM_WIDTH;
    localparam int RT = rmq_pkg::ROOT_WIDTH;
    localparam int RW = RT + 2;

    logic                 r_vld  [RT+1];
    logic [SW-1:0]        r_x    [RT+1];
    logic [RW-1:0]        r_rem  [RT+1];
    logic [RT-1:0]        r_root [RT+1];
    rmq_pkg::t_side       r_side [RT+1];

    assign r_vld[0]  = i_valid;
    assign r_x[0]    = i_sum;
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;
    assign r_side[0] = i_side;

    for (genvar k = 0; k < RT; k++) begin : g_step
        logic [RW+1:0] t;
        logic [RW+1:0] trial;
        always_comb begin
            t     = {r_rem[k], r_x[k][SW-1:SW-2]};
            trial = {2'b00, r_root[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= r_x[k] << 2;
                r_side[k+1] <= r_side[k];
                if (t >= trial) begin
                    r_rem[k+1]  <= RW'(t - trial);
                    r_root[k+1] <= {r_root[k][RT-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= RW'(t);
                    r_root[k+1] <= {r_root[k][RT-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[RT];
    assign o_root  = r_root[RT];
    assign o_side  = r_side[RT];

endmodule

// ----- rtl/core/rmq_div.sv -----
`timescale 1ns / 1ps

module rmq_div #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [rmq_pkg::ROOT_WIDTH-1:0]     i_norm,
    input  rmq_pkg::t_side                     i_side,
    output logic                               o_valid,
    output logic [3:0][FRAC_BITS:0]            o_quot,
    output rmq_pkg::t_side                     o_side
);

    localparam int NT = rmq_pkg::NORM_TOP;
    localparam int RT = rmq_pkg::ROOT_WIDTH;
    localparam int QW = FRAC_BITS + 1;
    localparam int NW = NT + 1 + FRAC_BITS;

    logic                  r_vld  [QW+1];
    logic [RT-1:0]         r_den  [QW+1];
    logic [3:0][RT-1:0]    r_rem  [QW+1];
    logic [3:0][QW-1:0]    r_lo   [QW+1];
    logic [3:0][QW-1:0]    r_q    [QW+1];
    rmq_pkg::t_side        r_side [QW+1];

    logic [NW-1:0]         num [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            num[i] = {1'b0, i_side.mag[i], {FRAC_BITS{1'b0}}} + NW'(i_norm >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_norm;
            r_side[0] <= i_side;
            for (int i = 0; i < 4; i++) begin
                r_rem[0][i] <= RT'(num[i][NW-1:QW]);
                r_lo[0][i]  <= num[i][QW-1:0];
                r_q[0][i]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [3:0][RT:0] t;
        always_comb begin
            for (int i = 0; i < 4; i++) begin
                t[i] = {r_rem[k][i], r_lo[k][i][QW-1]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
                for (int i = 0; i < 4; i++) begin
                    r_lo[k+1][i] <= r_lo[k][i] << 1;
                    if (t[i] >= {1'b0, r_den[k]}) begin
                        r_rem[k+1][i] <= RT'(t[i] - {1'b0, r_den[k]});
                        r_q[k+1][i]   <= {r_q[k][i][QW-2:0], 1'b1};
                    end else begin
                        r_rem[k+1][i] <= RT'(t[i]);
                        r_q[k+1][i]   <= {r_q[k][i][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quot  = r_q[QW];
    assign o_side  = r_side[QW];

endmodule

// ----- rtl/core/rotation_matrix_to_quaternion_unit.sv -----
`timescale 1ns / 1ps
// Rotation matrix to unit quaternion converter.
// The input channel takes one request per cycle: nine signed matrix
// elements on i_m_00 .. i_m_22, qualified by i_valid; o_stall pushes back.
// The output channel gives the normalised quaternion with the branch taken
// and an invalid flag, qualified by o_valid; the receiver drives i_stall.
// The block is one pipeline and accepts a request in every cycle that the
// output is not held. Four stages form the branch and normalise the
// magnitudes, three form the sum of squares, the square root takes one stage
// per root bit, the four dividers take a loading stage and one stage per
// quotient bit, and a final stage registers the result.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall is raised, so nothing is lost or repeated.
// Reset clears every valid bit; the first request may follow directly.
// An invalid result carries zero components and still names its branch.

module rotation_matrix_to_quaternion_unit #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_m_00,
    input  logic signed [DATA_WIDTH-1:0] i_m_01,
    input  logic signed [DATA_WIDTH-1:0] i_m_02,
    input  logic signed [DATA_WIDTH-1:0] i_m_10,
    input  logic signed [DATA_WIDTH-1:0] i_m_11,
    input  logic signed [DATA_WIDTH-1:0] i_m_12,
    input  logic signed [DATA_WIDTH-1:0] i_m_20,
    input  logic signed [DATA_WIDTH-1:0] i_m_21,
    input  logic signed [DATA_WIDTH-1:0] i_m_22,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_quat_x,
    output logic signed [DATA_WIDTH-1:0] o_quat_y,
    output logic signed [DATA_WIDTH-1:0] o_quat_z,
    output logic signed [DATA_WIDTH-1:0] o_quat_w,
    output logic [1:0]                   o_dominant_case,
    output logic                         o_invalid
);

    localparam int SQ = rmq_pkg::SQ_WIDTH;
    localparam int SW = rmq_pkg::SUM_WIDTH;
    localparam int RT = rmq_pkg::ROOT_WIDTH;
    localparam int QW = FRAC_BITS + 1;
    localparam int CW = ((QW > DATA_WIDTH) ? QW : DATA_WIDTH) + 1;
    localparam logic [CW-1:0] PMAX = (CW'(1) << (DATA_WIDTH - 1)) - CW'(1);

    logic                         en;
    logic signed [DATA_WIDTH-1:0] m [9];

    logic                         prep_vld;
    rmq_pkg::t_side               prep_side;

    logic                         r_sq_vld;
    logic [3:0][SQ-1:0]           r_sq;
    rmq_pkg::t_side               r_sq_side;
    logic                         r_pr_vld;
    logic [SQ:0]                  r_pr01;
    logic [SQ:0]                  r_pr23;
    rmq_pkg::t_side               r_pr_side;
    logic                         r_sum_vld;
    logic [SW-1:0]                r_sum;
    rmq_pkg::t_side               r_sum_side;

    logic                         rt_vld;
    logic [RT-1:0]                rt_root;
    rmq_pkg::t_side               rt_side;
    logic                         r_n_bad;

    logic                         dv_vld;
    logic [3:0][QW-1:0]           dv_quot;
    rmq_pkg::t_side               dv_side;
    logic [3:0]                   r_bad_pipe_unused;

    logic [DATA_WIDTH-1:0]        n_comp [4];
    logic [CW-1:0]                qe;
    logic [CW-1:0]                mag;

    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    assign m[0] = i_m_00;
    assign m[1] = i_m_01;
    assign m[2] = i_m_02;
    assign m[3] = i_m_10;
    assign m[4] = i_m_11;
    assign m[5] = i_m_12;
    assign m[6] = i_m_20;
    assign m[7] = i_m_21;
    assign m[8] = i_m_22;

    rmq_prep #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_m     (m),
        .o_valid (prep_vld),
        .o_side  (prep_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld  <= 1'b0;
            r_pr_vld  <= 1'b0;
            r_sum_vld <= 1'b0;
        end else if (en) begin
            r_sq_vld  <= prep_vld;
            r_pr_vld  <= r_sq_vld;
            r_sum_vld <= r_pr_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= SQ'(prep_side.mag[i]) * SQ'(prep_side.mag[i]);
            end
            r_sq_side  <= prep_side;
            r_pr01     <= (SQ + 1)'(r_sq[0]) + (SQ + 1)'(r_sq[1]);
            r_pr23     <= (SQ + 1)'(r_sq[2]) + (SQ + 1)'(r_sq[3]);
            r_pr_side  <= r_sq_side;
            r_sum      <= SW'(r_pr01) + SW'(r_pr23);
            r_sum_side <= r_pr_side;
        end
    end

    rmq_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sum_vld),
        .i_sum   (r_sum),
        .i_side  (r_sum_side),
        .o_valid (rt_vld),
        .o_root  (rt_root),
        .o_side  (rt_side)
    );

    rmq_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rt_vld),
        .i_norm  (rt_root),
        .i_side  (rt_side),
        .o_valid (dv_vld),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    // A zero norm is carried through the divider as one extra flag per item.
    logic r_nz_pipe [QW+2];
    assign r_nz_pipe[0] = (rt_root == '0);
    for (genvar k = 0; k < QW + 1; k++) begin : g_nz
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_nz_pipe[k+1] <= r_nz_pipe[k];
            end
        end
    end
    assign r_n_bad = r_nz_pipe[QW+1];
    assign r_bad_pipe_unused = '0;

    always_comb begin
        qe  = '0;
        mag = '0;
        for (int i = 0; i < 4; i++) begin
            qe = CW'(dv_quot[i]);
            if (dv_side.neg[i]) begin
                mag       = (qe > PMAX + CW'(1)) ? PMAX + CW'(1) : qe;
                n_comp[i] = DATA_WIDTH'(CW'(0) - mag);
            end else begin
                mag       = (qe > PMAX) ? PMAX : qe;
                n_comp[i] = DATA_WIDTH'(mag);
            end
            if (dv_side.bad || r_n_bad || (r_bad_pipe_unused[i])) begin
                n_comp[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_quat_x        <= n_comp[0];
            o_quat_y        <= n_comp[1];
            o_quat_z        <= n_comp[2];
            o_quat_w        <= n_comp[3];
            o_dominant_case <= dv_side.dcase;
            o_invalid       <= dv_side.bad || r_n_bad;
        end
    end

endmodule
